// ----- src/rrptb_pkg.sv -----
// Shared constants, codes and types for the round-robin picker with timed blocking.
package rrptb_pkg;

  localparam int ENTRIES     = 16;
  localparam int TIMER_BITS  = 16;
  localparam int IDX_BITS    = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS    = $clog2(ENTRIES + 1);
  localparam int MEMBER_BITS = 4;
  localparam int DUR_BITS    = 16;
  localparam int CHOSEN_BITS = 4;
  localparam int ACTIVE_BITS = 5;

  localparam logic [TIMER_BITS-1:0]  TIMER_MAX    = {TIMER_BITS{1'b1}};
  localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = ACTIVE_BITS'(16);

  typedef enum logic {
    OP_BLOCK = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  // Search state handed from one cell to the next.
  typedef struct packed {
    logic hi_seen;  // an available member at or after the pointer lies below
    logic lo_seen;  // an available member lies below
  } chain_t;

  // Per-cell pick flags for the two search passes.
  typedef struct packed {
    logic hi;
    logic lo;
  } take_t;

endpackage

// ----- src/rrptb_ifs.sv -----
// Request and result channel interfaces of the round-robin picker.
interface rrptb_req_if;
  logic                           valid;
  logic                           ready;
  rrptb_pkg::opcode_t             opcode;
  logic [rrptb_pkg::MEMBER_BITS-1:0] member;
  logic [rrptb_pkg::DUR_BITS-1:0]    duration;

  modport source (output valid, opcode, member, duration, input ready);
  modport sink   (input valid, opcode, member, duration, output ready);
endinterface

interface rrptb_res_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [rrptb_pkg::CHOSEN_BITS-1:0] chosen;

  modport source (output valid, found, chosen, input ready);
  modport sink   (input valid, found, chosen, output ready);
endinterface

// ----- src/round_robin_pick_with_timed_blocking.sv -----
// Top level: configuration register, pointer, row of member cells and result register.
// A tick request's result is registered in the output register in the cycle after acceptance.
// Throughput: one request per cycle, block or tick, while the result register is empty or
// being taken, set by the combinational ripple through the row of member cells.
// Block requests give no result. Reset is synchronous: all timers clear (everyone
// available), the pointer returns to zero and active_count returns to 16.
module round_robin_pick_with_timed_blocking (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rrptb_pkg::ACTIVE_BITS-1:0] cfg_wdata,
  rrptb_req_if.sink                         item,
  rrptb_res_if.source                       result
);
  import rrptb_pkg::*;

  logic [ACTIVE_BITS-1:0] active_count;
  logic [CNT_BITS-1:0]    eff_count;
  logic [IDX_BITS-1:0]    ptr;
  logic [IDX_BITS-1:0]    ptr_next;
  logic [TIMER_BITS-1:0]  dur_sat;
  logic                   accept;
  logic                   blk_en;
  logic                   tick_en;
  chain_t                 chain [ENTRIES+1];
  take_t                  take  [ENTRIES];
  logic [ENTRIES-1:0]     sel;
  logic                   any_found;
  logic [IDX_BITS-1:0]    pick;
  logic [CNT_BITS:0]      pick_inc;
  logic                   res_valid;
  logic                   res_found;
  logic [CHOSEN_BITS-1:0] res_chosen;

  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign blk_en     = accept && (item.opcode == OP_BLOCK);
  assign tick_en    = accept && (item.opcode == OP_TICK);

  assign eff_count = (int'(active_count) > ENTRIES) ? CNT_BITS'(ENTRIES)
                                                     : CNT_BITS'(active_count);

  always_comb begin
    if (TIMER_BITS >= DUR_BITS) begin
      dur_sat = TIMER_BITS'(item.duration);
    end else if (item.duration > DUR_BITS'(TIMER_MAX)) begin
      dur_sat = TIMER_MAX;
    end else begin
      dur_sat = TIMER_BITS'(item.duration);
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rrptb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (IDX_BITS'(i)),
      .eff_count (eff_count),
      .ptr       (ptr),
      .blk_en    (blk_en),
      .member    (item.member),
      .dur       (dur_sat),
      .tick_en   (tick_en),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .take      (take[i])
    );
    // Prefer the first member at or after the pointer, else wrap to the lowest.
    assign sel[i] = chain[ENTRIES].hi_seen ? take[i].hi : take[i].lo;
  end

  assign any_found = chain[ENTRIES].lo_seen;

  always_comb begin
    pick = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        pick = pick | IDX_BITS'(i);
      end
    end
  end

  assign pick_inc = (CNT_BITS + 1)'(pick) + (CNT_BITS + 1)'(1);

  always_comb begin
    if (!any_found || (pick_inc >= (CNT_BITS + 1)'(eff_count))) begin
      ptr_next = '0;
    end else begin
      ptr_next = IDX_BITS'(pick_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= ACTIVE_RESET;
      ptr          <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_count <= cfg_wdata;
      end
      if (tick_en) begin
        ptr       <= ptr_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      res_found  <= any_found;
      res_chosen <= any_found ? CHOSEN_BITS'(pick) : '0;
    end
  end

  assign result.valid  = res_valid;
  assign result.found  = res_found;
  assign result.chosen = res_chosen;

  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    tick_en |=> result.valid)
    else $error("tick request did not produce a result");

  a_single_pick: assert property (@(posedge clk) disable iff (rst)
    $onehot0(sel) && (any_found == (sel != '0)))
    else $error("pick select is not one-hot or disagrees with found");

  a_none_resets_ptr: assert property (@(posedge clk) disable iff (rst)
    (tick_en && !any_found) |=> (ptr == '0))
    else $error("pointer not returned to zero after an empty tick");

  a_none_chosen_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.found) |-> (result.chosen == '0))
    else $error("chosen not zero when nothing was found");

endmodule

// ----- src/rrptb_cell.sv -----
// One member cell: its block timer and one stage of the rotating search chain.
module rrptb_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [rrptb_pkg::IDX_BITS-1:0]    idx,
  input  logic [rrptb_pkg::CNT_BITS-1:0]    eff_count,
  input  logic [rrptb_pkg::IDX_BITS-1:0]    ptr,
  input  logic                              blk_en,
  input  logic [rrptb_pkg::MEMBER_BITS-1:0] member,
  input  logic [rrptb_pkg::TIMER_BITS-1:0]  dur,
  input  logic                              tick_en,
  input  rrptb_pkg::chain_t                 chain_in,
  output rrptb_pkg::chain_t                 chain_out,
  output rrptb_pkg::take_t                  take
);
  import rrptb_pkg::*;

  logic [TIMER_BITS-1:0] timer;
  logic [TIMER_BITS-1:0] timer_next;
  logic                  avail;
  logic                  hi_cand;
  logic                  hit;

  assign hit     = blk_en && (int'(member) == int'(idx));
  assign avail   = (timer == '0) && (CNT_BITS'(idx) < eff_count);
  assign hi_cand = avail && (idx >= ptr);

  assign take.hi           = hi_cand && !chain_in.hi_seen;
  assign take.lo           = avail && !chain_in.lo_seen;
  assign chain_out.hi_seen = chain_in.hi_seen || hi_cand;
  assign chain_out.lo_seen = chain_in.lo_seen || avail;

  // A later block only ever extends the release; a tick counts down.
  always_comb begin
    timer_next = timer;
    if (hit && (dur > timer)) begin
      timer_next = dur;
    end else if (tick_en && (timer != '0)) begin
      timer_next = timer - TIMER_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else begin
      timer <= timer_next;
    end
  end

endmodule

// ----- tb/round_robin_pick_with_timed_blocking_tb.sv -----
// Self-checking testbench for the round-robin picker with timed blocking.
module round_robin_pick_with_timed_blocking_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrptb_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_PAUSE  = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int NO_PICK      = -1;
  localparam int RANDOM_ITEMS = 110;

  typedef struct packed {
    opcode_t               opcode;
    logic [MEMBER_BITS-1:0] member;
    logic [DUR_BITS-1:0]    duration;
  } request_t;

  typedef struct packed {
    logic                   found;
    logic [CHOSEN_BITS-1:0] chosen;
  } pick_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [ACTIVE_BITS-1:0] cfg_wdata;

  rrptb_req_if req_ch ();
  rrptb_res_if res_ch ();

  round_robin_pick_with_timed_blocking DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (req_ch),
    .result    (res_ch)
  );

  // Predictor state.
  logic [TIMER_BITS-1:0]  timer_m [ENTRIES];
  int                     pointer_m;
  logic [ACTIVE_BITS-1:0] active_m;

  request_t pending_requests [$];
  pick_t    expected_picks [$];

  request_t cur_req;
  logic     holding;
  int       send_gap;
  int       recv_stall;
  logic     src_steady;
  logic     sink_steady;
  logic     backpressure_go;
  logic     drain_hold;
  int       errors;
  int       cycle_count;

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_BLOCK;
    req_ch.member    = '0;
    req_ch.duration  = '0;
    res_ch.ready     = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Updates the predicted timers and pointer for one accepted request, and queues the expected pick of a tick.
  task automatic apply_request(input request_t r);
    int    lim;
    int    hit;
    pick_t p;
    if (r.opcode == OP_BLOCK) begin
      if (r.duration > timer_m[r.member]) timer_m[r.member] = r.duration;
    end else begin
      lim = (active_m > ENTRIES) ? ENTRIES : int'(active_m);
      hit = NO_PICK;
      for (int i = pointer_m; i < lim && hit == NO_PICK; i++)
        if (timer_m[i] == '0) hit = i;
      for (int i = 0; i < lim && hit == NO_PICK; i++)
        if (timer_m[i] == '0) hit = i;
      if (hit != NO_PICK) pointer_m = (hit + 1 >= lim) ? 0 : hit + 1;
      else pointer_m = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (timer_m[i] != '0) timer_m[i] = timer_m[i] - 1'b1;
      p.found  = (hit != NO_PICK);
      p.chosen = (hit != NO_PICK) ? CHOSEN_BITS'(hit) : '0;
      expected_picks = {expected_picks, p};
    end
  endtask

  task automatic check_pick(input logic found, input logic [CHOSEN_BITS-1:0] chosen);
    pick_t want;
    if (expected_picks.size() == 0) begin
      note_mismatch($sformatf("result found=%0b chosen=%0d with no tick waiting",
                              found, chosen));
    end else begin
      want = expected_picks.pop_front();
      if (found !== want.found)
        note_mismatch($sformatf("found: expected %0b, got %0b", want.found, found));
      if (chosen !== want.chosen)
        note_mismatch($sformatf("chosen: expected %0d, got %0d", want.chosen, chosen));
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      holding = 1'b0;
      send_gap = 0;
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_request(cur_req);
        holding = 1'b0;
        send_gap = src_steady ? 0 : idle_length();
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() != 0) begin
          cur_req = pending_requests.pop_front();
          holding = 1'b1;
        end
      end
      req_ch.valid    <= holding;
      req_ch.opcode   <= cur_req.opcode;
      req_ch.member   <= cur_req.member;
      req_ch.duration <= cur_req.duration;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      recv_stall = 0;
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_pick(res_ch.found, res_ch.chosen);
      if (recv_stall > 0) recv_stall--;
      else if (!sink_steady) recv_stall = idle_length();
      res_ch.ready <= !drain_hold && recv_stall == 0;
    end
  end

  // A long hold-off on the result side, so that the block fills and stalls its input.
  initial begin
    drain_hold = 1'b0;
    wait (backpressure_go);
    @(posedge clk);
    drain_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    drain_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** round_robin_pick_with_timed_blocking: FAILED **");
      $finish;
    end
  end

  task automatic queue_request(input opcode_t op, input int who, input int dur);
    request_t r;
    r.opcode   = op;
    r.member   = MEMBER_BITS'(who);
    r.duration = DUR_BITS'(dur);
    pending_requests = {pending_requests, r};
  endtask

  // Returns once every request has been taken and every result has come back.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || holding || expected_picks.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_active(input int value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ACTIVE_BITS'(value);
    @(posedge clk);
    cfg_we   <= 1'b0;
    active_m = ACTIVE_BITS'(value);
  endtask

  task automatic queue_random_phase(input int count);
    int top;
    int r;
    top = (active_m == 0) ? 0 : ((active_m > ENTRIES) ? ENTRIES - 1 : int'(active_m) - 1);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 1) begin
        queue_request(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 65535));
      end else begin
        r = $urandom_range(0, 99);
        queue_request(OP_BLOCK,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, top),
                      (r < 5)  ? 0 :
                      (r < 85) ? $urandom_range(1, 2 * top + 2) :
                      (r < 99) ? $urandom_range(1, 64) : $urandom_range(100, 600));
      end
    end
  endtask

  initial begin
    int cfg_plan [12];
    errors          = 0;
    cycle_count     = 0;
    src_steady      = 1'b0;
    sink_steady     = 1'b0;
    backpressure_go = 1'b0;
    pointer_m       = 0;
    active_m        = ACTIVE_RESET;
    for (int i = 0; i < ENTRIES; i++) timer_m[i] = '0;
    cfg_plan = '{16, 3, 1, 8, 17, 2, 16, 31, 5, 12, 0, 16};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed requests with the reset member count.
    queue_request(OP_TICK, 0, 0);
    queue_request(OP_TICK, 15, 65535);
    queue_request(OP_BLOCK, 2, 1);
    queue_request(OP_BLOCK, 5, 0);       // a zero duration changes nothing
    queue_request(OP_BLOCK, 3, 3);
    queue_request(OP_BLOCK, 3, 1);       // the overlapping shorter block must not win
    queue_request(OP_TICK, 0, 0);
    queue_request(OP_TICK, 0, 0);
    queue_request(OP_BLOCK, 15, 2);
    queue_request(OP_TICK, 0, 0);
    write_active(1);
    queue_request(OP_TICK, 0, 0);
    queue_request(OP_BLOCK, 0, 1);
    queue_request(OP_TICK, 0, 0);        // nobody available
    queue_request(OP_TICK, 0, 0);
    write_active(0);
    queue_request(OP_TICK, 0, 0);
    write_active(31);
    queue_request(OP_TICK, 0, 0);

    for (int p = 0; p < 12; p++) begin
      write_active(cfg_plan[p]);
      src_steady  = ($urandom_range(0, 3) == 0) || (p == 6);
      sink_steady = ($urandom_range(0, 3) == 0);
      queue_random_phase(RANDOM_ITEMS);
      if (p == 6) backpressure_go = 1'b1;
    end

    // Longest blocks last, so that they do not starve the random phases.
    write_active(16);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    queue_request(OP_BLOCK, 0, 65535);
    queue_request(OP_BLOCK, 15, 65535);
    queue_request(OP_TICK, 0, 0);
    queue_request(OP_TICK, 0, 0);
    queue_request(OP_TICK, 0, 0);

    wait_idle();
    if (errors == 0) begin
      $display("** round_robin_pick_with_timed_blocking: PASSED **");
    end else begin
      $display("** round_robin_pick_with_timed_blocking: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rrptb_pkg.sv
src/rrptb_ifs.sv
src/rrptb_cell.sv
src/round_robin_pick_with_timed_blocking.sv
tb/round_robin_pick_with_timed_blocking_tb.sv
